// ===== rtl/core/nlv_pkg.sv =====
// Shared types and constants of the neighborhood label vote block.
package nlv_pkg;

	// One stored pixel: charge flag and signed label.
	typedef struct packed {
		logic       charge;
		logic [4:0] label;
	} nlv_pix_t;

	// Control from the sequencer to the vote unit.
	typedef struct packed {
		logic clear;
		logic valid;
		logic ign_zero;
	} nlv_tly_ctl_t;

	localparam int unsigned PIX_W = $bits(nlv_pix_t);

	// Configuration register indexes.
	localparam logic [1:0] CFG_IGNORE_ZERO = 2'd0;
	localparam logic [1:0] CFG_ROWS        = 2'd1;
	localparam logic [1:0] CFG_COLS        = 2'd2;

	// Input kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Reply codes.
	localparam logic signed [4:0] NO_VOTE_CODE   = -5'sd1;
	localparam logic signed [4:0] NO_CHARGE_CODE = -5'sd2;

	// Last row or column step of the window.
	localparam logic [1:0] WIN_LAST = 2'd2;

endpackage

// ===== rtl/core/nlv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nlv_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/nlv_tally.sv =====
// Vote unit: counts each new vote against earlier ones and tracks the leader.
module nlv_tally #(
	parameter int MAX_LABEL = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nlv_pkg::nlv_tly_ctl_t ctl,
	input  nlv_pkg::nlv_pix_t    pix,
	output logic signed [4:0]    pixel_type
);
	import nlv_pkg::*;

	localparam int HIST = 8;

	logic [3:0] vlab_q [HIST];
	logic       vval_q [HIST];
	logic       charged_q;
	logic       voted_q;
	logic [3:0] best_q;
	logic [3:0] bestn_q;

	logic       casts;
	logic [3:0] hits;
	logic [3:0] n_votes;
	logic       take;

	// A charged pixel votes when its label is non-negative, in range and not
	// a suppressed zero.
	always_comb begin
		casts = pix.charge && !pix.label[4]
			&& !(ctl.ign_zero && (pix.label[3:0] == 4'd0))
			&& ({3'b000, pix.label} <= 8'(MAX_LABEL));
		hits = 4'd0;
		for (int j = 0; j < HIST; j++) begin
			if (vval_q[j] && (vlab_q[j] == pix.label[3:0])) begin
				hits = hits + 4'd1;
			end
		end
		n_votes = hits + 4'd1;
		take = casts && ((n_votes > bestn_q)
			|| ((n_votes == bestn_q) && (pix.label[3:0] < best_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charged_q <= 1'b0;
			voted_q   <= 1'b0;
			bestn_q   <= 4'd0;
			best_q    <= 4'd0;
			for (int j = 0; j < HIST; j++) begin
				vval_q[j] <= 1'b0;
			end
		end else if (ctl.clear) begin
			charged_q <= 1'b0;
			voted_q   <= 1'b0;
			bestn_q   <= 4'd0;
			best_q    <= 4'd0;
			for (int j = 0; j < HIST; j++) begin
				vval_q[j] <= 1'b0;
			end
		end else if (ctl.valid) begin
			charged_q <= charged_q | pix.charge;
			voted_q   <= voted_q | casts;
			if (take) begin
				best_q  <= pix.label[3:0];
				bestn_q <= n_votes;
			end
			vval_q[0] <= casts;
			for (int j = 1; j < HIST; j++) begin
				vval_q[j] <= vval_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			vlab_q[0] <= pix.label[3:0];
			for (int j = 1; j < HIST; j++) begin
				vlab_q[j] <= vlab_q[j-1];
			end
		end
	end

	always_comb begin
		if (voted_q) begin
			pixel_type = {1'b0, best_q};
		end else if (charged_q) begin
			pixel_type = NO_VOTE_CODE;
		end else begin
			pixel_type = NO_CHARGE_CODE;
		end
	end

endmodule

// ===== rtl/core/neighborhood_label_vote.sv =====
// Top level of the 3x3 neighborhood label vote block.
// A write transaction is stored as it is accepted; the next can follow at once.
// A query reads nine window pixels, one per cycle from the single RAM read port, and
// the tally takes the last one in the following cycle, in ST_DRAIN; the result is then
// offered in ST_OUT, and the block takes no new input until it is delivered.
// arst_n clears control state and registers; the pixel RAM is not cleared.
module neighborhood_label_vote #(
	parameter int IMG_ROWS  = 256,
	parameter int IMG_COLS  = 256,
	parameter int MAX_LABEL = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] row, [15:8] col, [16] charge_present, [21:17] label, [23:22] zero
	input  logic [23:0] s_axis_tdata,
	// [0] kind
	input  logic [0:0]  s_axis_tuser,
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] pixel_type, [7:5] zero
	output logic [7:0]  m_axis_tdata,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import nlv_pkg::*;

	// The RAM is addressed by row and column bit fields side by side.
	localparam int RW    = $clog2(IMG_ROWS);
	localparam int CW    = $clog2(IMG_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int SZW   = 13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_OUT
	} state_t;

	state_t       state_q;
	logic         ign_zero_q;
	logic [8:0]   rows_q;
	logic [8:0]   cols_q;
	logic [7:0]   crow_q;
	logic [7:0]   ccol_q;
	logic [8:0]   maxr_q;
	logic [8:0]   maxc_q;
	logic [1:0]   ri_q;
	logic [1:0]   ci_q;
	logic         rd_pend_q;

	logic         in_acc;
	logic         out_acc;
	logic [7:0]   in_row;
	logic [7:0]   in_col;
	nlv_pix_t     in_pix;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	logic [SZW-1:0] eff_rows;
	logic [SZW-1:0] eff_cols;
	logic [8:0]   rd_row;
	logic [8:0]   rd_col;
	logic         rd_en;
	logic [AW-1:0] rd_addr;
	nlv_pix_t     rd_pix;
	nlv_tly_ctl_t tly_ctl;
	logic signed [4:0] pixel_type;

	// Clamp of one window coordinate: center plus offset minus one, held
	// between zero and the last index in use.
	function automatic logic [8:0] clamp_coord(input logic [7:0] center,
		input logic [1:0] off, input logic [8:0] maxv);
		logic [9:0] t;
		logic [8:0] v;
		t = {2'b00, center} + {8'd0, off};
		v = (t == 10'd0) ? 9'd0 : 9'(t - 10'd1);
		return (v > maxv) ? maxv : v;
	endfunction

	assign in_row = s_axis_tdata[7:0];
	assign in_col = s_axis_tdata[15:8];
	assign in_pix = '{charge: s_axis_tdata[16], label: s_axis_tdata[21:17]};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_acc       = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = {3'b000, pixel_type};

	// Writes land in the accept cycle; those outside the stored image drop.
	assign wr_en = in_acc && (s_axis_tuser[0] == KIND_WRITE)
		&& ({5'd0, in_row} < SZW'(IMG_ROWS)) && ({5'd0, in_col} < SZW'(IMG_COLS));
	assign wr_addr = {RW'(in_row), CW'(in_col)};

	// Image size in use: zero reads as one, anything above the stored size
	// saturates to it.
	always_comb begin
		if (rows_q == 9'd0) begin
			eff_rows = SZW'(1);
		end else if ({4'd0, rows_q} > SZW'(IMG_ROWS)) begin
			eff_rows = SZW'(IMG_ROWS);
		end else begin
			eff_rows = {4'd0, rows_q};
		end
		if (cols_q == 9'd0) begin
			eff_cols = SZW'(1);
		end else if ({4'd0, cols_q} > SZW'(IMG_COLS)) begin
			eff_cols = SZW'(IMG_COLS);
		end else begin
			eff_cols = {4'd0, cols_q};
		end
	end

	// Window read address for the current row and column step.
	assign rd_row  = clamp_coord(crow_q, ri_q, maxr_q);
	assign rd_col  = clamp_coord(ccol_q, ci_q, maxc_q);
	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = {RW'(rd_row), CW'(rd_col)};

	assign tly_ctl = '{
		clear:    in_acc && (s_axis_tuser[0] == KIND_QUERY),
		valid:    rd_pend_q,
		ign_zero: ign_zero_q
	};

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_zero_q <= 1'b0;
			rows_q     <= 9'd256;
			cols_q     <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IGNORE_ZERO: ign_zero_q <= cfg_data[0];
				CFG_ROWS:        rows_q     <= cfg_data;
				CFG_COLS:        cols_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Query sequencer: walks the window row by row, one RAM read per cycle,
	// then waits for the last read data before offering the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ri_q      <= 2'd0;
			ci_q      <= 2'd0;
			rd_pend_q <= 1'b0;
			crow_q    <= 8'd0;
			ccol_q    <= 8'd0;
			maxr_q    <= 9'd0;
			maxc_q    <= 9'd0;
		end else begin
			rd_pend_q <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser[0] == KIND_QUERY)) begin
						crow_q  <= in_row;
						ccol_q  <= in_col;
						maxr_q  <= 9'(eff_rows - SZW'(1));
						maxc_q  <= 9'(eff_cols - SZW'(1));
						ri_q    <= 2'd0;
						ci_q    <= 2'd0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (ci_q == WIN_LAST) begin
						ci_q <= 2'd0;
						if (ri_q == WIN_LAST) begin
							state_q <= ST_DRAIN;
						end else begin
							ri_q <= ri_q + 2'd1;
						end
					end else begin
						ci_q <= ci_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	nlv_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(in_pix),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_pix)
	);

	nlv_tally #(
		.MAX_LABEL(MAX_LABEL)
	) u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tly_ctl),
		.pix       (rd_pix),
		.pixel_type(pixel_type)
	);

endmodule

// ===== rtl/core/nlv_checker.sv =====
// Port-level checker for the neighborhood label vote block, with its bind.
module nlv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);
	import nlv_pkg::*;

	// A pending result holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// Only one item is in the block at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while a result is pending");

	// No result can follow an accepted transaction in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result appeared too early");

	// Delivering a result frees the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> s_axis_tready)
		else $error("block not ready after result");

	// A reply is a non-negative label or one of the two codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:5] == 3'b000) && (!m_axis_tdata[4]
			|| (m_axis_tdata[4:0] == NO_VOTE_CODE)
			|| (m_axis_tdata[4:0] == NO_CHARGE_CODE)))
		else $error("reply outside its range");

endmodule

bind neighborhood_label_vote nlv_checker u_nlv_checker (.*);

// ===== test/tb_neighborhood_label_vote.sv =====
// Self-checking testbench for the 3x3 neighborhood label vote block.
module tb_neighborhood_label_vote;
	timeunit 1ns;
	timeprecision 1ps;

	import nlv_pkg::*;

	localparam int IMG_ROWS       = 256;
	localparam int IMG_COLS       = 256;
	localparam int MAX_LABEL      = 15;
	localparam int MAP_DEPTH      = IMG_ROWS * IMG_COLS;
	localparam int CLK_PERIOD     = 20;
	// Covers the run of a query from acceptance to its result, with margin on top.
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 163;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [7:0] row, [15:8] col, [16] charge_present, [21:17] label, [23:22] zero
	logic [23:0] s_axis_tdata  = '0;
	// [0] kind
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [4:0] pixel_type, [7:5] zero
	logic [7:0]  m_axis_tdata;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [8:0]  cfg_data      = '0;

	neighborhood_label_vote #(
		.IMG_ROWS (IMG_ROWS),
		.IMG_COLS (IMG_COLS),
		.MAX_LABEL(MAX_LABEL)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the two pixel images. written_img tracks which pixels
	// have been stored at least once, so that no query ever reads a pixel
	// whose contents are undefined.
	bit         charge_img  [0:MAP_DEPTH-1];
	logic [4:0] label_img   [0:MAP_DEPTH-1];
	bit         written_img [0:MAP_DEPTH-1];

	// Shadow copy of the configuration registers, reset values included.
	bit         ign_zero_sh = 1'b0;
	logic [8:0] rows_sh     = 9'd256;
	logic [8:0] cols_sh     = 9'd256;

	// Expected pixel_type of every query accepted but not yet answered.
	logic [4:0] pending_votes [$];
	logic [4:0] vote_want;

	int fail_count     = 0;
	int items_sent     = 0;
	int quiet_cycles   = 0;
	int send_gap_pct   = 0;
	int sink_stall_pct = 0;
	int sink_hold_req  = 0;
	int sink_hold_left = 0;

	// One row of the directed table: a pixel write, a query or a register write.
	typedef enum logic [1:0] {ROW_PIXEL, ROW_QUERY, ROW_REG} row_op_t;

	typedef struct {
		row_op_t    op;
		logic [7:0] r;
		logic [7:0] c;
		logic       ch;
		logic [4:0] lab;
		logic [1:0] reg_idx;
		logic [8:0] reg_val;
		bit         typed;
		logic [4:0] want;
	} plan_row_t;

	plan_row_t plan [$];

	function automatic void plan_pixel(input logic [7:0] r, c, input logic ch,
			input logic [4:0] lab);
		plan_row_t p;
		p = '{op: ROW_PIXEL, r: r, c: c, ch: ch, lab: lab, reg_idx: '0, reg_val: '0,
			typed: 1'b0, want: '0};
		plan.push_back(p);
	endfunction

	function automatic void plan_query(input logic [7:0] r, c, input bit typed,
			input logic [4:0] want);
		plan_row_t p;
		p = '{op: ROW_QUERY, r: r, c: c, ch: 1'b0, lab: '0, reg_idx: '0, reg_val: '0,
			typed: typed, want: want};
		plan.push_back(p);
	endfunction

	function automatic void plan_reg(input logic [1:0] idx, input logic [8:0] val);
		plan_row_t p;
		p = '{op: ROW_REG, r: '0, c: '0, ch: 1'b0, lab: '0, reg_idx: idx, reg_val: val,
			typed: 1'b0, want: '0};
		plan.push_back(p);
	endfunction

	// Rows and columns of the 3x3 window after clamping to the image in use.
	// A size register of zero behaves as one, and a size above the stored
	// image saturates to the stored image.
	function automatic void window_coords(input logic [7:0] r, c, output int wr[3],
			output int wc[3]);
		int top_r;
		int top_c;
		int v;
		top_r = (rows_sh == 0) ? 0 : (rows_sh > IMG_ROWS) ? IMG_ROWS - 1 : int'(rows_sh) - 1;
		top_c = (cols_sh == 0) ? 0 : (cols_sh > IMG_COLS) ? IMG_COLS - 1 : int'(cols_sh) - 1;
		for (int k = 0; k < 3; k++) begin
			v = int'(r) + k - 1;
			wr[k] = (v < 0) ? 0 : (v > top_r) ? top_r : v;
			v = int'(c) + k - 1;
			wc[k] = (v < 0) ? 0 : (v > top_c) ? top_c : v;
		end
	endfunction

	// Predicts the reply to a query: the label with the most votes among the
	// charged window pixels, the smallest label winning a tie.
	function automatic logic [4:0] window_vote(input logic [7:0] r, c);
		int         wr [3];
		int         wc [3];
		int         tally [MAX_LABEL+1];
		bit         charged;
		bit         voted;
		int         best;
		int         best_n;
		int         a;
		logic [4:0] lab;
		window_coords(r, c, wr, wc);
		charged = 1'b0;
		voted   = 1'b0;
		best    = 0;
		best_n  = 0;
		for (int k = 0; k <= MAX_LABEL; k++)
			tally[k] = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				a = wr[i] * IMG_COLS + wc[j];
				if (!charge_img[a])
					continue;
				charged = 1'b1;
				lab = label_img[a];
				// Negative labels and, when asked, label zero cast no vote.
				if (lab[4] || (lab == 0 && ign_zero_sh) || lab > MAX_LABEL)
					continue;
				tally[lab]++;
				voted = 1'b1;
			end
		end
		if (!voted)
			return charged ? NO_VOTE_CODE : NO_CHARGE_CODE;
		for (int k = 0; k <= MAX_LABEL; k++) begin
			if (tally[k] > best_n) begin
				best_n = tally[k];
				best   = k;
			end
		end
		return 5'(best);
	endfunction

	// Labels lean toward a few small values so that windows often hold
	// majorities and ties; the rest cover every code including negatives.
	function automatic logic [4:0] rand_label();
		int roll;
		roll = $urandom_range(1, 10);
		if (roll <= 6)
			return 5'($urandom_range(0, 3));
		if (roll <= 8)
			return 5'($urandom_range(0, 31));
		return 5'h1F;
	endfunction

	function automatic logic rand_charge();
		return $urandom_range(0, 3) != 0;
	endfunction

	function automatic int pick_base();
		int roll;
		roll = $urandom_range(1, 4);
		if (roll == 1)
			return 0;
		if (roll == 2)
			return 248;
		return $urandom_range(0, 248);
	endfunction

	// Offers one input transaction and returns at the rising edge where it is
	// accepted. The shadow images and the expectation queue are updated right
	// there, so the prediction always sees the state the block sees.
	task automatic send_item(input logic kind, input logic [7:0] r, c, input logic ch,
			input logic [4:0] lab, input bit typed, input logic [4:0] want);
		int a;
		@(negedge clk);
		while (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, lab, ch, c, r};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (kind == KIND_WRITE) begin
			a = int'(r) * IMG_COLS + int'(c);
			charge_img[a]  = ch;
			label_img[a]   = lab;
			written_img[a] = 1'b1;
		end else begin
			pending_votes.push_back(typed ? want : window_vote(r, c));
		end
	endtask

	// Writes every pixel of the window that has never been stored, so that
	// the query that follows reads only defined pixels.
	task automatic fill_window(input logic [7:0] r, c);
		int wr [3];
		int wc [3];
		window_coords(r, c, wr, wc);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (!written_img[wr[i] * IMG_COLS + wc[j]])
					send_item(KIND_WRITE, 8'(wr[i]), 8'(wc[j]), rand_charge(), rand_label(),
						1'b0, '0);
	endtask

	// Lowers the input valid, then waits until every expected result has come
	// back and the block has had time to finish any trailing work.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_votes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Registers are only written while the block is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_IGNORE_ZERO: ign_zero_sh = val[0];
			CFG_ROWS:        rows_sh     = val;
			CFG_COLS:        cols_sh     = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: tready is redrawn every falling edge. A long hold-off, once
	// requested, is counted down here while the sender keeps offering work, so
	// the block holds its one pending result and must stall its input.
	always @(negedge clk) begin
		if (sink_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_left--;
		end else if (sink_hold_req != 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_left = sink_hold_req;
			sink_hold_req  = 0;
		end else begin
			m_axis_tready <= ($urandom_range(1, 100) > sink_stall_pct);
		end
	end

	// Every result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_votes.size() == 0) begin
				$display("%0t: result with nothing expected, got pixel_type %0d", $time,
					$signed(m_axis_tdata[4:0]));
				fail_count++;
			end else begin
				vote_want = pending_votes.pop_front();
				if (m_axis_tdata[4:0] !== vote_want) begin
					$display("%0t: pixel_type mismatch, expected %0d, got %0d", $time,
						$signed(vote_want), $signed(m_axis_tdata[4:0]));
					fail_count++;
				end
			end
		end
	end

	// The run is abandoned when neither side moves a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		plan_row_t  step;
		int         stop_at;
		int         pick;
		int         base_r;
		int         base_c;
		logic [7:0] r;
		logic [7:0] c;
		logic [8:0] rows_pick [PHASES];
		logic [8:0] cols_pick [PHASES];

		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. The corner window at the origin starts uncharged,
		// then gains an unlabelled pixel, a zero label and a top label.
		plan_pixel(8'd0, 8'd0, 1'b0, 5'd0);
		plan_pixel(8'd0, 8'd1, 1'b0, 5'd0);
		plan_pixel(8'd1, 8'd0, 1'b0, 5'h10);
		plan_pixel(8'd1, 8'd1, 1'b0, 5'd0);
		plan_query(8'd0, 8'd0, 1'b1, NO_CHARGE_CODE);
		plan_pixel(8'd1, 8'd1, 1'b1, 5'h1F);
		plan_query(8'd0, 8'd0, 1'b1, NO_VOTE_CODE);
		plan_pixel(8'd0, 8'd0, 1'b1, 5'd0);
		plan_query(8'd0, 8'd0, 1'b1, 5'd0);
		plan_reg(CFG_IGNORE_ZERO, 9'd1);
		plan_query(8'd0, 8'd0, 1'b1, NO_VOTE_CODE);
		plan_pixel(8'd0, 8'd1, 1'b1, 5'd15);
		plan_query(8'd0, 8'd0, 1'b1, 5'd15);
		// Image shrunk to zero behaves as a single pixel; the far centre is
		// clamped onto the origin, whose zero label is ignored, then counted.
		plan_reg(CFG_ROWS, 9'd0);
		plan_reg(CFG_COLS, 9'd0);
		plan_query(8'd255, 8'd255, 1'b1, NO_VOTE_CODE);
		plan_reg(CFG_IGNORE_ZERO, 9'd0);
		plan_query(8'd255, 8'd255, 1'b1, 5'd0);
		// Oversized registers saturate; the far corner window ties 7 against
		// 3 at four votes each, and the smaller label wins.
		plan_reg(CFG_ROWS, 9'd511);
		plan_reg(CFG_COLS, 9'd511);
		plan_pixel(8'd255, 8'd255, 1'b1, 5'd7);
		plan_pixel(8'd254, 8'd255, 1'b1, 5'd3);
		plan_pixel(8'd255, 8'd254, 1'b1, 5'd3);
		plan_pixel(8'd254, 8'd254, 1'b0, 5'h1F);
		plan_query(8'd255, 8'd255, 1'b1, 5'd3);
		// A one-row image folds the window onto a single row.
		plan_reg(CFG_ROWS, 9'd1);
		plan_reg(CFG_COLS, 9'd256);
		plan_pixel(8'd0, 8'd127, 1'b1, 5'd9);
		plan_pixel(8'd0, 8'd128, 1'b1, 5'd9);
		plan_pixel(8'd0, 8'd129, 1'b1, 5'd2);
		plan_query(8'd0, 8'd128, 1'b0, '0);

		for (int n = 0; n < plan.size(); n++) begin
			step = plan[n];
			case (step.op)
				ROW_PIXEL: send_item(KIND_WRITE, step.r, step.c, step.ch, step.lab, 1'b0, '0);
				ROW_QUERY: send_item(KIND_QUERY, step.r, step.c, 1'b0, '0, step.typed, step.want);
				default:   write_reg(step.reg_idx, step.reg_val);
			endcase
		end

		// Random phases. Each phase picks an image size, the zero-label
		// setting and an idling pattern, then mostly works a small hot area
		// where writes and queries overlap, with some writes and queries
		// spread over the whole coordinate range.
		rows_pick = '{9'd256, 9'd1, 9'd511, 9'd3, 9'($urandom_range(1, 256)),
			9'($urandom_range(0, 511)), 9'd0, 9'($urandom_range(1, 256))};
		cols_pick = '{9'd256, 9'd2, 9'd300, 9'd511, 9'($urandom_range(1, 256)), 9'd0,
			9'($urandom_range(1, 256)), 9'd1};
		for (int phase = 0; phase < PHASES; phase++) begin
			write_reg(CFG_IGNORE_ZERO, 9'(phase % 3 == 1));
			write_reg(CFG_ROWS, rows_pick[phase]);
			write_reg(CFG_COLS, cols_pick[phase]);
			case (phase % 4)
				0: begin
					send_gap_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 71;
					sink_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					sink_stall_pct = 71;
				end
				default: begin
					send_gap_pct   = 34;
					sink_stall_pct = 34;
				end
			endcase
			// With the sender running flat out, hold the result side off.
			if (phase == 4)
				sink_hold_req = HOLD_CYCLES;
			base_r  = pick_base();
			base_c  = pick_base();
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at) begin
				pick = $urandom_range(1, 100);
				if (pick <= 35) begin
					send_item(KIND_WRITE, 8'(base_r + $urandom_range(0, 7)),
						8'(base_c + $urandom_range(0, 7)), rand_charge(), rand_label(), 1'b0, '0);
				end else if (pick <= 45) begin
					send_item(KIND_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						rand_charge(), rand_label(), 1'b0, '0);
				end else begin
					if (pick <= 85) begin
						r = 8'(base_r + $urandom_range(0, 7));
						c = 8'(base_c + $urandom_range(0, 7));
					end else begin
						r = 8'($urandom_range(0, 255));
						c = 8'($urandom_range(0, 255));
					end
					fill_window(r, c);
					// Write-only fields carry noise on a query.
					send_item(KIND_QUERY, r, c, 1'($urandom_range(0, 1)),
						5'($urandom_range(0, 31)), 1'b0, '0);
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/nlv_pkg.sv
rtl/core/nlv_ram.sv
rtl/core/nlv_tally.sv
rtl/core/neighborhood_label_vote.sv
rtl/core/nlv_checker.sv
test/tb_neighborhood_label_vote.sv
